FILE: sv/volume_adjoint_gradient_stencil_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the gradient stencil
// Clocked property wrappers used by the top-level stencil module.
// ----------------------------------------------------------------------------
`ifndef VOLUME_ADJOINT_GRADIENT_STENCIL_MACROS_SVH
`define VOLUME_ADJOINT_GRADIENT_STENCIL_MACROS_SVH

// Property checked at every edge outside reset
`define VAGS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Cause in one cycle implies effect in the next
`define VAGS_ASSERT_NEXT(lbl, cause, effect, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cause) |=> (effect)) \
    else $error(msg);

`endif

FILE: sv/vags_pkg.sv
// ----------------------------------------------------------------------------
// vags_pkg
// Shared constants and types of the adjoint gradient stencil.
// ----------------------------------------------------------------------------
`default_nettype none
package vags_pkg;

  localparam int MAX_ROW     = 64;
  localparam int MAX_PLANE   = 4096;
  localparam int MAX_DEPTH   = 1024;
  localparam int SAMPLE_BITS = 16;

  localparam int RING_DEPTH = 2 * MAX_PLANE;
  localparam int RING_AW    = $clog2(RING_DEPTH);
  localparam int PLANE_W    = $clog2(MAX_PLANE + 1);
  localparam int GAIN_W     = 18;
  localparam int DIFF_W     = SAMPLE_BITS + 1;
  localparam int PROD_W     = GAIN_W + DIFF_W;
  localparam int RESULT_W   = 40;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  // Configuration register indexes
  localparam logic [2:0] REG_SIZE_X = 3'd0;
  localparam logic [2:0] REG_SIZE_Y = 3'd1;
  localparam logic [2:0] REG_SIZE_Z = 3'd2;
  localparam logic [2:0] REG_GAIN_X = 3'd3;
  localparam logic [2:0] REG_GAIN_Y = 3'd4;
  localparam logic [2:0] REG_GAIN_Z = 3'd5;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [GAIN_W-1:0]      gain_t;

  // Per-read context travelling alongside the memory read
  typedef struct packed {
    logic          valid;
    logic          last;
    logic [2:0]    bwd;      // backward difference, per axis x,y,z
    logic [2:0]    fwd_here; // center read hits same-cycle write
    logic [2:0]    fwd_nb;   // neighbor read hits same-cycle write
    sample_t [2:0] wdata;    // sample written in the read cycle
  } stage_t;

endpackage
`default_nettype wire

FILE: sv/vags_ram.sv
// ----------------------------------------------------------------------------
// vags_ram
// Simple memory, one write port and two registered read ports.
// ----------------------------------------------------------------------------
`default_nettype none
module vags_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8192
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic      [WIDTH-1:0]         rdata_a,
  output logic      [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule
`default_nettype wire

FILE: sv/vags_calc.sv
// ----------------------------------------------------------------------------
// vags_calc
// Differences, gain products and the final sum, with a registered product stage.
// ----------------------------------------------------------------------------
`default_nettype none
module vags_calc (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire vags_pkg::stage_t           st,
  input  wire vags_pkg::sample_t [2:0]    rd_here,
  input  wire vags_pkg::sample_t [2:0]    rd_nb,
  input  wire vags_pkg::gain_t   [2:0]    gain,
  output logic                            push,
  output logic [vags_pkg::RESULT_W-1:0]   push_result,
  output logic                            push_last,
  output logic                            busy
);
  import vags_pkg::*;

  sample_t [2:0]                   here_c;
  sample_t [2:0]                   nb_c;
  logic signed [2:0][DIFF_W-1:0]   diff;
  logic signed [2:0][PROD_W-1:0]   prod;
  logic                            pvalid;
  logic                            plast;
  logic signed [PROD_W+1:0]        sum;

  // Forward same-cycle writes, then form the difference per axis
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      here_c[a] = st.fwd_here[a] ? st.wdata[a] : rd_here[a];
      nb_c[a]   = st.fwd_nb[a]   ? st.wdata[a] : rd_nb[a];
      diff[a]   = st.bwd[a] ? (DIFF_W'($signed(here_c[a])) - DIFF_W'($signed(nb_c[a])))
                            : (DIFF_W'($signed(nb_c[a]))   - DIFF_W'($signed(here_c[a])));
    end
  end

  // Product stage
  always_ff @(posedge clk) begin
    if (rst) begin
      pvalid <= 1'b0;
    end else begin
      pvalid <= st.valid;
    end
    plast <= st.last;
    for (int a = 0; a < 3; a++) begin
      prod[a] <= PROD_W'($signed(gain[a]) * $signed(diff[a]));
    end
  end

  // Sum stage feeds the output queue directly
  assign sum = (PROD_W+2)'($signed(prod[0])) + (PROD_W+2)'($signed(prod[1]))
             + (PROD_W+2)'($signed(prod[2]));
  assign push        = pvalid;
  assign push_result = RESULT_W'(sum);
  assign push_last   = plast;
  assign busy        = pvalid;

endmodule
`default_nettype wire

FILE: sv/vags_fifo.sv
// ----------------------------------------------------------------------------
// vags_fifo
// Small result queue decoupling the stream output from the pipeline.
// ----------------------------------------------------------------------------
`default_nettype none
module vags_fifo (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          push,
  input  wire logic [vags_pkg::RESULT_W:0]   push_data,
  input  wire logic                          pop,
  output logic                               not_empty,
  output logic [vags_pkg::RESULT_W:0]        head,
  output logic [vags_pkg::FIFO_AW:0]         count
);
  import vags_pkg::*;

  logic [RESULT_W:0]  mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wptr;
  logic [FIFO_AW-1:0] rptr;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= push_data;
    end
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (pop)  rptr <= rptr + 1'b1;
      count <= count + (FIFO_AW+1)'(push) - (FIFO_AW+1)'(pop);
    end
  end

  assign not_empty = (count != '0);
  assign head      = mem[rptr];

endmodule
`default_nettype wire

FILE: sv/volume_adjoint_gradient_stencil.sv
// A voxel's result is released when the voxel one plane later arrives (or by
//   a drain transfer), then passes the context, product and queue registers.
// Throughput: one transfer per cycle; one ring read per axis memory port pair.
// Input is held off while queued plus in-flight results reach the queue depth.
// Reset (rst, synchronous): counters, queue and config return to defaults;
//   the sample ring is not cleared and is only read after being written.
`default_nettype none
module volume_adjoint_gradient_stencil (
  input  wire logic        clk,
  input  wire logic        rst,
  // config write channel
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [17:0] cfg_data,
  // input stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [47:0] s_axis_tdata,  // x_sample, y_sample, z_sample
  input  wire logic        s_axis_tuser,  // func
  // output stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0]      m_axis_tdata,  // result
  output logic             m_axis_tlast   // last_voxel
);
  import vags_pkg::*;

  // Configuration registers
  logic [6:0]    size_x;
  logic [6:0]    size_y;
  logic [10:0]   size_z;
  gain_t [2:0]   gain;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      size_x  <= 7'd64;
      size_y  <= 7'd64;
      size_z  <= 11'd64;
      gain[0] <= -18'sd4096;
      gain[1] <= -18'sd4096;
      gain[2] <= -18'sd4096;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_SIZE_X: size_x  <= cfg_data[6:0];
        REG_SIZE_Y: size_y  <= cfg_data[6:0];
        REG_SIZE_Z: size_z  <= cfg_data[10:0];
        REG_GAIN_X: gain[0] <= cfg_data;
        REG_GAIN_Y: gain[1] <= cfg_data;
        REG_GAIN_Z: gain[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Rows allowed per plane for a given row length
  logic [PLANE_W-1:0] row_lim [128];
  for (genvar g = 0; g < 128; g++) begin : g_lim
    localparam int Div = (g < 2) ? 2 : g;
    assign row_lim[g] = PLANE_W'(MAX_PLANE / Div);
  end

  // Effective sizes
  logic [6:0]          nx;
  logic [6:0]          ny;
  logic [10:0]         nz;
  logic [PLANE_W-1:0]  plane;

  always_comb begin
    if (size_x < 7'd2)              nx = 7'd2;
    else if (size_x > 7'(MAX_ROW))  nx = 7'(MAX_ROW);
    else                            nx = size_x;
    if (size_y < 7'd2)                           ny = 7'd2;
    else if (PLANE_W'(size_y) > row_lim[nx])     ny = 7'(row_lim[nx]);
    else                                         ny = size_y;
    if (size_z < 11'd2)                nz = 11'd2;
    else if (size_z > 11'(MAX_DEPTH))  nz = 11'(MAX_DEPTH);
    else                               nz = size_z;
    plane = PLANE_W'(nx * ny);
  end

  // Stream control state
  logic [RING_AW-1:0] waddr;
  logic [RING_AW-1:0] eaddr;
  logic [RING_AW-1:0] pend;     // stored minus emitted
  logic               rdone;
  logic [6:0]         rx, ry;
  logic [10:0]        rz;
  logic [6:0]         ex, ey;
  logic [10:0]        ez;

  logic               acc, wr, rel, rlast, elast;
  logic [RING_AW-1:0] pend_w;
  logic [2:0]         bwd;
  logic [RING_AW-1:0] nb [3];
  logic [FIFO_AW:0]   occ;
  logic [FIFO_AW:0]   fifo_cnt;
  logic               calc_busy;
  stage_t             st;
  stage_t             st_next;
  sample_t [2:0]      win;
  sample_t [2:0]      rd_here;
  sample_t [2:0]      rd_nb;

  assign win[0] = s_axis_tdata[15:0];
  assign win[1] = s_axis_tdata[31:16];
  assign win[2] = s_axis_tdata[47:32];

  // Credit: results in flight plus queued never exceed the queue depth
  assign occ           = fifo_cnt + (FIFO_AW+1)'(st.valid) + (FIFO_AW+1)'(calc_busy);
  assign s_axis_tready = (occ < (FIFO_AW+1)'(FIFO_DEPTH));
  assign acc           = s_axis_tvalid && s_axis_tready;

  // Store decision and release decision for this transfer
  always_comb begin
    rlast  = (rx == nx - 7'd1) && (ry == ny - 7'd1) && (rz == nz - 11'd1);
    elast  = (ex == nx - 7'd1) && (ey == ny - 7'd1) && (ez == nz - 11'd1);
    wr     = acc && !s_axis_tuser && !rdone;
    pend_w = pend + RING_AW'(wr);
    rel    = acc && ((pend_w > RING_AW'(plane)) || (s_axis_tuser && rdone));
    bwd[0] = (ex == nx - 7'd1);
    bwd[1] = (ey == ny - 7'd1);
    bwd[2] = (ez == nz - 11'd1);
    nb[0]  = bwd[0] ? eaddr - RING_AW'(1) : eaddr + RING_AW'(1);
    nb[1]  = bwd[1] ? eaddr - RING_AW'(nx) : eaddr + RING_AW'(nx);
    nb[2]  = bwd[2] ? eaddr - RING_AW'(plane) : eaddr + RING_AW'(plane);
    st_next.valid = rel;
    st_next.last  = elast;
    st_next.bwd   = bwd;
    st_next.wdata = win;
    for (int a = 0; a < 3; a++) begin
      st_next.fwd_here[a] = wr && (eaddr == waddr);
      st_next.fwd_nb[a]   = wr && (nb[a] == waddr);
    end
  end

  // Counters
  always_ff @(posedge clk) begin
    if (rst) begin
      waddr <= '0; eaddr <= '0; pend <= '0; rdone <= 1'b0;
      rx <= '0; ry <= '0; rz <= '0;
      ex <= '0; ey <= '0; ez <= '0;
    end else if (rel && elast) begin
      // Whole volume emitted: restart
      waddr <= '0; eaddr <= '0; pend <= '0; rdone <= 1'b0;
      rx <= '0; ry <= '0; rz <= '0;
      ex <= '0; ey <= '0; ez <= '0;
    end else begin
      pend <= rel ? pend_w - RING_AW'(1) : pend_w;
      if (wr) begin
        waddr <= waddr + RING_AW'(1);
        if (rlast) rdone <= 1'b1;
        if (rx == nx - 7'd1) begin
          rx <= '0;
          if (ry == ny - 7'd1) begin
            ry <= '0;
            rz <= rz + 11'd1;
          end else begin
            ry <= ry + 7'd1;
          end
        end else begin
          rx <= rx + 7'd1;
        end
      end
      if (rel) begin
        eaddr <= eaddr + RING_AW'(1);
        if (ex == nx - 7'd1) begin
          ex <= '0;
          if (ey == ny - 7'd1) begin
            ey <= '0;
            ez <= ez + 11'd1;
          end else begin
            ey <= ey + 7'd1;
          end
        end else begin
          ex <= ex + 7'd1;
        end
      end
    end
  end

  // Read context register
  always_ff @(posedge clk) begin
    if (rst) begin
      st.valid <= 1'b0;
    end else begin
      st.valid <= st_next.valid;
    end
    st.last     <= st_next.last;
    st.bwd      <= st_next.bwd;
    st.fwd_here <= st_next.fwd_here;
    st.fwd_nb   <= st_next.fwd_nb;
    st.wdata    <= st_next.wdata;
  end

  // One sample ring per component
  for (genvar a = 0; a < 3; a++) begin : g_ring
    vags_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(RING_DEPTH)) u_ring (
      .clk     (clk),
      .we      (wr),
      .waddr   (waddr),
      .wdata   (win[a]),
      .raddr_a (eaddr),
      .raddr_b (nb[a]),
      .rdata_a (rd_here[a]),
      .rdata_b (rd_nb[a])
    );
  end

  logic                push;
  logic [RESULT_W-1:0] push_result;
  logic                push_last;
  logic [RESULT_W:0]   head;

  vags_calc u_calc (
    .clk         (clk),
    .rst         (rst),
    .st          (st),
    .rd_here     (rd_here),
    .rd_nb       (rd_nb),
    .gain        (gain),
    .push        (push),
    .push_result (push_result),
    .push_last   (push_last),
    .busy        (calc_busy)
  );

  vags_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data ({push_last, push_result}),
    .pop       (m_axis_tvalid && m_axis_tready),
    .not_empty (m_axis_tvalid),
    .head      (head),
    .count     (fifo_cnt)
  );

  assign m_axis_tdata = head[RESULT_W-1:0];
  assign m_axis_tlast = head[RESULT_W];

`include "volume_adjoint_gradient_stencil_macros.svh"

  `VAGS_ASSERT(a_no_overflow, occ <= (FIFO_AW+1)'(FIFO_DEPTH), "result queue overrun")
  `VAGS_ASSERT(a_center_not_written, !(rel && wr && (eaddr == waddr)), "center read races write")
  `VAGS_ASSERT_NEXT(a_restart, rel && elast, (pend == '0) && !rdone && (waddr == '0), "no restart")

endmodule
`default_nettype wire
